// File: rtl/core/mid_pkg.sv
// mips iii instruction decoder package: identifier enum, result struct
// and the opcode, special, regimm and fp function lookup functions
// no dependencies
`default_nettype none

package mid_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned IdWidth   = 8;
  localparam int unsigned CondWidth = 4;

  // identifiers, the base set in mnemonic order before the cop0 and fp groups, none is the invalid code
  typedef enum logic [IdWidth-1:0] {
    ID_NONE, ID_ADD, ID_ADDI, ID_ADDIU, ID_ADDU, ID_AND, ID_ANDI, ID_BEQ, ID_BEQL,
    ID_BGEZ, ID_BGEZAL, ID_BGEZALL, ID_BGEZL, ID_BGTZ, ID_BGTZL, ID_BLEZ, ID_BLEZL,
    ID_BLTZ, ID_BLTZAL, ID_BLTZALL, ID_BLTZL, ID_BNE, ID_BNEL, ID_BREAK, ID_DADD,
    ID_DADDI, ID_DADDIU, ID_DADDU, ID_DDIV, ID_DDIVU, ID_DIV, ID_DIVU, ID_DMULT,
    ID_DMULTU, ID_DSLL, ID_DSLL32, ID_DSLLV, ID_DSRA, ID_DSRA32, ID_DSRAV, ID_DSRL,
    ID_DSRL32, ID_DSRLV, ID_DSUB, ID_DSUBU, ID_ERET, ID_J, ID_JAL, ID_JALR, ID_JR,
    ID_LB, ID_LBU, ID_LD, ID_LDL, ID_LDR, ID_LH, ID_LHU, ID_LL, ID_LLD, ID_LUI, ID_LW,
    ID_LWL, ID_LWR, ID_LWU, ID_MFHI, ID_MFLO, ID_MTHI, ID_MTLO, ID_MULT, ID_MULTU,
    ID_NOR, ID_OR, ID_ORI, ID_SB, ID_SC, ID_SCD, ID_SD, ID_SDL, ID_SDR, ID_SH, ID_SLL,
    ID_SLLV, ID_SLT, ID_SLTI, ID_SLTIU, ID_SLTU, ID_SRA, ID_SRAV, ID_SRL, ID_SRLV,
    ID_SUB, ID_SUBU, ID_SW, ID_SWL, ID_SWR, ID_SYNC, ID_SYSCALL, ID_TEQ, ID_TEQI,
    ID_TGE, ID_TGEI, ID_TGEIU, ID_TGEU, ID_TLT, ID_TLTI, ID_TLTIU, ID_TLTU, ID_TNE,
    ID_TNEI, ID_XOR, ID_XORI, ID_BC0F, ID_BC0FL, ID_BC0T, ID_BC0TL, ID_DMFC0,
    ID_DMTC0, ID_MFC0, ID_MTC0, ID_CACHE, ID_TLBP, ID_TLBR, ID_TLBWI, ID_TLBWR,
    ID_ABS_F, ID_ADD_F, ID_BC1F, ID_BC1FL, ID_BC1T, ID_BC1TL, ID_CEIL_L, ID_CEIL_W,
    ID_CFC1, ID_CTC1, ID_CVT_D, ID_CVT_L, ID_CVT_S, ID_CVT_W, ID_DIV_F, ID_DMFC1,
    ID_DMTC1, ID_C_COND, ID_FLOOR_L, ID_FLOOR_W, ID_LDC1, ID_LWC1, ID_MFC1,
    ID_MOV_F, ID_MTC1, ID_MUL_F, ID_NEG_F, ID_ROUND_L, ID_ROUND_W, ID_SDC1,
    ID_SQRT_F, ID_SUB_F, ID_SWC1, ID_TRUNC_L, ID_TRUNC_W
  } instr_id_t;

  localparam instr_id_t IdLast = ID_TRUNC_W;

  // primary opcodes that leave the main table
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_COP0    = 6'd16;
  localparam logic [5:0] OP_COP1    = 6'd17;

  // cop1 fmt codes
  localparam logic [4:0] FMT_MF  = 5'd0;
  localparam logic [4:0] FMT_DMF = 5'd1;
  localparam logic [4:0] FMT_CF  = 5'd2;
  localparam logic [4:0] FMT_MT  = 5'd4;
  localparam logic [4:0] FMT_DMT = 5'd5;
  localparam logic [4:0] FMT_CT  = 5'd6;
  localparam logic [4:0] FMT_BC  = 5'd8;
  localparam logic [4:0] FMT_S   = 5'd16;
  localparam logic [4:0] FMT_D   = 5'd17;
  localparam logic [4:0] FMT_W   = 5'd20;
  localparam logic [4:0] FMT_L   = 5'd21;

  // cop0 rs codes and co functions
  localparam logic [4:0] RS_MF  = 5'd0;
  localparam logic [4:0] RS_DMF = 5'd1;
  localparam logic [4:0] RS_MT  = 5'd4;
  localparam logic [4:0] RS_DMT = 5'd5;
  localparam logic [4:0] RS_BC  = 5'd8;
  localparam logic [5:0] CO_TLBR  = 6'd1;
  localparam logic [5:0] CO_TLBWI = 6'd2;
  localparam logic [5:0] CO_TLBWR = 6'd6;
  localparam logic [5:0] CO_TLBP  = 6'd8;
  localparam logic [5:0] CO_ERET  = 6'd24;

  typedef struct packed {
    instr_id_t             id;
    logic [CondWidth-1:0]  cond;
  } mid_result_t;

  function automatic instr_id_t main_lookup(input logic [5:0] op);
    instr_id_t r;
    unique case (op)
      6'd2:  r = ID_J;      6'd3:  r = ID_JAL;    6'd4:  r = ID_BEQ;    6'd5:  r = ID_BNE;
      6'd6:  r = ID_BLEZ;   6'd7:  r = ID_BGTZ;   6'd8:  r = ID_ADDI;   6'd9:  r = ID_ADDIU;
      6'd10: r = ID_SLTI;   6'd11: r = ID_SLTIU;  6'd12: r = ID_ANDI;   6'd13: r = ID_ORI;
      6'd14: r = ID_XORI;   6'd15: r = ID_LUI;    6'd20: r = ID_BEQL;   6'd21: r = ID_BNEL;
      6'd22: r = ID_BLEZL;  6'd23: r = ID_BGTZL;  6'd24: r = ID_DADDI;  6'd25: r = ID_DADDIU;
      6'd26: r = ID_LDL;    6'd27: r = ID_LDR;    6'd32: r = ID_LB;     6'd33: r = ID_LH;
      6'd34: r = ID_LWL;    6'd35: r = ID_LW;     6'd36: r = ID_LBU;    6'd37: r = ID_LHU;
      6'd38: r = ID_LWR;    6'd39: r = ID_LWU;    6'd40: r = ID_SB;     6'd41: r = ID_SH;
      6'd42: r = ID_SWL;    6'd43: r = ID_SW;     6'd44: r = ID_SDL;    6'd45: r = ID_SDR;
      6'd46: r = ID_SWR;    6'd47: r = ID_CACHE;  6'd48: r = ID_LL;     6'd49: r = ID_LWC1;
      6'd52: r = ID_LLD;    6'd53: r = ID_LDC1;   6'd55: r = ID_LD;     6'd56: r = ID_SC;
      6'd57: r = ID_SWC1;   6'd60: r = ID_SCD;    6'd61: r = ID_SDC1;   6'd63: r = ID_SD;
      default: r = ID_NONE;
    endcase
    return r;
  endfunction

  function automatic instr_id_t special_lookup(input logic [5:0] fn);
    instr_id_t r;
    unique case (fn)
      6'd0:  r = ID_SLL;     6'd2:  r = ID_SRL;     6'd3:  r = ID_SRA;     6'd4:  r = ID_SLLV;
      6'd6:  r = ID_SRLV;    6'd7:  r = ID_SRAV;    6'd8:  r = ID_JR;      6'd9:  r = ID_JALR;
      6'd12: r = ID_SYSCALL; 6'd13: r = ID_BREAK;   6'd15: r = ID_SYNC;    6'd16: r = ID_MFHI;
      6'd17: r = ID_MTHI;    6'd18: r = ID_MFLO;    6'd19: r = ID_MTLO;    6'd20: r = ID_DSLLV;
      6'd22: r = ID_DSRLV;   6'd23: r = ID_DSRAV;   6'd24: r = ID_MULT;    6'd25: r = ID_MULTU;
      6'd26: r = ID_DIV;     6'd27: r = ID_DIVU;    6'd28: r = ID_DMULT;   6'd29: r = ID_DMULTU;
      6'd30: r = ID_DDIV;    6'd31: r = ID_DDIVU;   6'd32: r = ID_ADD;     6'd33: r = ID_ADDU;
      6'd34: r = ID_SUB;     6'd35: r = ID_SUBU;    6'd36: r = ID_AND;     6'd37: r = ID_OR;
      6'd38: r = ID_XOR;     6'd39: r = ID_NOR;     6'd42: r = ID_SLT;     6'd43: r = ID_SLTU;
      6'd44: r = ID_DADD;    6'd45: r = ID_DADDU;   6'd46: r = ID_DSUB;    6'd47: r = ID_DSUBU;
      6'd48: r = ID_TGE;     6'd49: r = ID_TGEU;    6'd50: r = ID_TLT;     6'd51: r = ID_TLTU;
      6'd52: r = ID_TEQ;     6'd54: r = ID_TNE;     6'd56: r = ID_DSLL;    6'd58: r = ID_DSRL;
      6'd59: r = ID_DSRA;    6'd60: r = ID_DSLL32;  6'd62: r = ID_DSRL32;  6'd63: r = ID_DSRA32;
      default: r = ID_NONE;
    endcase
    return r;
  endfunction

  function automatic instr_id_t regimm_lookup(input logic [4:0] rt);
    instr_id_t r;
    unique case (rt)
      5'd0:  r = ID_BLTZ;    5'd1:  r = ID_BGEZ;    5'd2:  r = ID_BLTZL;   5'd3:  r = ID_BGEZL;
      5'd8:  r = ID_TGEI;    5'd9:  r = ID_TGEIU;   5'd10: r = ID_TLTI;    5'd11: r = ID_TLTIU;
      5'd12: r = ID_TEQI;    5'd14: r = ID_TNEI;    5'd16: r = ID_BLTZAL;  5'd17: r = ID_BGEZAL;
      5'd18: r = ID_BLTZALL; 5'd19: r = ID_BGEZALL;
      default: r = ID_NONE;
    endcase
    return r;
  endfunction

  function automatic instr_id_t fpfn_lookup(input logic [5:0] fn);
    instr_id_t r;
    unique case (fn) inside
      6'd0:  r = ID_ADD_F;   6'd1:  r = ID_SUB_F;   6'd2:  r = ID_MUL_F;   6'd3:  r = ID_DIV_F;
      6'd4:  r = ID_SQRT_F;  6'd5:  r = ID_ABS_F;   6'd6:  r = ID_MOV_F;   6'd7:  r = ID_NEG_F;
      6'd8:  r = ID_ROUND_L; 6'd9:  r = ID_TRUNC_L; 6'd10: r = ID_CEIL_L;  6'd11: r = ID_FLOOR_L;
      6'd12: r = ID_ROUND_W; 6'd13: r = ID_TRUNC_W; 6'd14: r = ID_CEIL_W;  6'd15: r = ID_FLOOR_W;
      6'd32: r = ID_CVT_S;   6'd33: r = ID_CVT_D;   6'd36: r = ID_CVT_W;   6'd37: r = ID_CVT_L;
      [6'd48:6'd63]: r = ID_C_COND;
      default: r = ID_NONE;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/mid_decode.sv
// combinational decode of one instruction word, by opcode and then by the function, rs or rt field
// depends on mid_pkg
`default_nettype none

module mid_decode (
  input  wire logic [mid_pkg::WordWidth-1:0] word,
  output mid_pkg::mid_result_t               result
);

  logic [5:0] op;
  logic [4:0] rs;
  logic [4:0] rt;
  logic [5:0] fn;
  mid_pkg::instr_id_t cop0_id;
  mid_pkg::instr_id_t cop1_id;
  mid_pkg::instr_id_t fp_id;
  mid_pkg::instr_id_t id;

  assign op = word[31:26];
  assign rs = word[25:21];
  assign rt = word[20:16];
  assign fn = word[5:0];

  always_comb begin
    if (rs[4]) begin
      unique case (fn)
        mid_pkg::CO_TLBR:  cop0_id = mid_pkg::ID_TLBR;
        mid_pkg::CO_TLBWI: cop0_id = mid_pkg::ID_TLBWI;
        mid_pkg::CO_TLBWR: cop0_id = mid_pkg::ID_TLBWR;
        mid_pkg::CO_TLBP:  cop0_id = mid_pkg::ID_TLBP;
        mid_pkg::CO_ERET:  cop0_id = mid_pkg::ID_ERET;
        default:           cop0_id = mid_pkg::ID_NONE;
      endcase
    end else begin
      unique case (rs)
        mid_pkg::RS_MF:  cop0_id = mid_pkg::ID_MFC0;
        mid_pkg::RS_DMF: cop0_id = mid_pkg::ID_DMFC0;
        mid_pkg::RS_MT:  cop0_id = mid_pkg::ID_MTC0;
        mid_pkg::RS_DMT: cop0_id = mid_pkg::ID_DMTC0;
        mid_pkg::RS_BC: begin
          unique case (rt[1:0])
            2'd0:    cop0_id = mid_pkg::ID_BC0F;
            2'd1:    cop0_id = mid_pkg::ID_BC0T;
            2'd2:    cop0_id = mid_pkg::ID_BC0FL;
            default: cop0_id = mid_pkg::ID_BC0TL;
          endcase
        end
        default: cop0_id = mid_pkg::ID_NONE;
      endcase
    end
  end

  // fixed-point formats only convert, and no conversion to its own format
  always_comb begin
    fp_id = mid_pkg::fpfn_lookup(fn);
    if ((rs == mid_pkg::FMT_W || rs == mid_pkg::FMT_L) &&
        fp_id != mid_pkg::ID_CVT_S && fp_id != mid_pkg::ID_CVT_D) begin
      fp_id = mid_pkg::ID_NONE;
    end else if (fp_id == mid_pkg::ID_CVT_S && rs == mid_pkg::FMT_S) begin
      fp_id = mid_pkg::ID_NONE;
    end else if (fp_id == mid_pkg::ID_CVT_D && rs == mid_pkg::FMT_D) begin
      fp_id = mid_pkg::ID_NONE;
    end
  end

  always_comb begin
    unique case (rs)
      mid_pkg::FMT_MF:  cop1_id = mid_pkg::ID_MFC1;
      mid_pkg::FMT_DMF: cop1_id = mid_pkg::ID_DMFC1;
      mid_pkg::FMT_CF:  cop1_id = mid_pkg::ID_CFC1;
      mid_pkg::FMT_MT:  cop1_id = mid_pkg::ID_MTC1;
      mid_pkg::FMT_DMT: cop1_id = mid_pkg::ID_DMTC1;
      mid_pkg::FMT_CT:  cop1_id = mid_pkg::ID_CTC1;
      mid_pkg::FMT_BC: begin
        unique case (rt[1:0])
          2'd0:    cop1_id = mid_pkg::ID_BC1F;
          2'd1:    cop1_id = mid_pkg::ID_BC1T;
          2'd2:    cop1_id = mid_pkg::ID_BC1FL;
          default: cop1_id = mid_pkg::ID_BC1TL;
        endcase
      end
      mid_pkg::FMT_S, mid_pkg::FMT_D, mid_pkg::FMT_W, mid_pkg::FMT_L: cop1_id = fp_id;
      default: cop1_id = mid_pkg::ID_NONE;
    endcase
  end

  always_comb begin
    unique case (op)
      mid_pkg::OP_SPECIAL: id = mid_pkg::special_lookup(fn);
      mid_pkg::OP_REGIMM:  id = mid_pkg::regimm_lookup(rt);
      mid_pkg::OP_COP0:    id = cop0_id;
      mid_pkg::OP_COP1:    id = cop1_id;
      default:             id = mid_pkg::main_lookup(op);
    endcase
  end

  assign result.id   = id;
  assign result.cond = (id == mid_pkg::ID_C_COND) ? word[3:0] : '0;

endmodule

`default_nettype wire

// File: rtl/core/mips64_instruction_decode.sv
// MIPS III instruction decoder: one 32-bit word in, one identifier out. Every
// word is registered on transfer, decoded by a single combinational pass and
// registered again, and a new word is accepted every cycle while the result
// side keeps up. The result register lets one more word enter while a finished
// result waits.
// depends on mid_pkg and mid_decode
`default_nettype none

module mips64_instruction_decode (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // instruction_word[31:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // instr_id[7:0], fp_compare_cond[11:8], zero[15:12]
  output logic             m_axis_tuser    // is_valid
);

  logic                              in_valid;
  logic [mid_pkg::WordWidth-1:0]     in_word;
  logic                              out_ready;
  logic                              in_ready;
  mid_pkg::mid_result_t              dec_result;
  mid_pkg::mid_result_t              out_result;

  assign out_ready     = !m_axis_tvalid || m_axis_tready;
  assign in_ready      = !in_valid || out_ready;
  assign s_axis_tready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && s_axis_tvalid) begin
      in_word <= s_axis_tdata;
    end
  end

  mid_decode u_decode (
    .word   (in_word),
    .result (dec_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && in_valid) begin
      out_result <= dec_result;
    end
  end

  assign m_axis_tdata = {4'b0000, out_result.cond, out_result.id};
  assign m_axis_tuser = (out_result.id != mid_pkg::ID_NONE);

endmodule

`default_nettype wire

// File: rtl/core/mid_checker.sv
// port-level checks on the instruction decoder and their bind
// depends on mid_pkg and mips64_instruction_decode
`default_nettype none

module mid_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  logic [7:0] id;
  logic [3:0] cond;

  assign id   = m_axis_tdata[7:0];
  assign cond = m_axis_tdata[11:8];

  // nothing left over after reset
  a_reset_clear: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_valid_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == (id != 8'd0)))
    else $error("is_valid disagrees with instr_id");

  a_cond_only_compare: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && cond != 4'd0) |-> (id == 8'(mid_pkg::ID_C_COND)))
    else $error("compare condition on a non-compare identifier");

  a_id_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (id <= 8'(mid_pkg::IdLast) && m_axis_tdata[15:12] == 4'd0))
    else $error("identifier out of range or padding set");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind mips64_instruction_decode mid_checker u_mid_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
